@@ design/mcspg_pkg.sv @@
`default_nettype none

package mcspg_pkg;

  // Channel count that the block is built for by default, and its upper limit.
  localparam int NUM_SERVOS_DEF = 18;
  localparam int MAX_SERVOS     = 32;

  // Channels that own a pin on one of the three port groups.
  localparam int PIN_COUNT = 18;

  localparam int WIDTH_W = 16;
  localparam int FRAME_W = 16;
  localparam int SHIFT_W = 4;
  localparam int SIDX_W  = 8;
  localparam int IDX_W   = $clog2(MAX_SERVOS);

  localparam int PORT_B_W = 6;
  localparam int PORT_C_W = 4;
  localparam int PORT_D_W = 8;

  localparam logic [FRAME_W-1:0] FRAME_TICKS_RST = 16'd5000;
  localparam logic [SHIFT_W-1:0] TICK_SHIFT_RST  = 4'd2;

  // Request codes.
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Configuration register indexes.
  localparam int   CFG_IDX_W       = 1;
  localparam logic CFG_FRAME_TICKS = 1'b0;
  localparam logic CFG_TICK_SHIFT  = 1'b1;

  // Command queue between the decoder and the pulse engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Port groups of the pin map.
  localparam logic [1:0] GRP_B = 2'd0;
  localparam logic [1:0] GRP_C = 2'd1;
  localparam logic [1:0] GRP_D = 2'd2;

  localparam logic [1:0] PIN_GROUP [PIN_COUNT] = '{
    GRP_D, GRP_D, GRP_D, GRP_D, GRP_D,
    GRP_B, GRP_B, GRP_B, GRP_B, GRP_B, GRP_B,
    GRP_C, GRP_C, GRP_C, GRP_C,
    GRP_D, GRP_D, GRP_D
  };

  localparam logic [2:0] PIN_BIT [PIN_COUNT] = '{
    3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd0, 3'd1, 3'd2, 3'd3,
    3'd0, 3'd1, 3'd2
  };

  // One classified request as it travels from the decoder to the engine.
  typedef struct packed {
    logic               is_tick;
    logic               set_en;
    logic [IDX_W-1:0]   index;
    logic [WIDTH_W-1:0] width;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/multi_channel_servo_pulse_generator_core.sv @@
`default_nettype none

// Servo pulse generator for up to eighteen pinned channels.
// The input channel carries two kinds of request: a set request stores a new
// pulse width in microseconds for one servo (unknown servo numbers are
// dropped), and a tick request advances the frame timer by one tick.
// Every request returns exactly one result transfer carrying the levels of
// the B, C and D pin groups and a flag that marks the first tick of a frame.
// A set request returns the pin levels unchanged with the flag low.
// Widths are latched for all channels at the first tick of each frame, so a
// new width takes effect at the next frame boundary.
// A request passes through the command queue and then the output register
// before its result can be transferred, and while the receiver does not
// stall the block sustains one transfer per cycle; the per-channel compare
// of tick count against shifted width is combinational.
// A two-entry command queue separates the decoder from the pulse engine. When
// the receiver stalls, the output register holds its result until taken, the
// queue keeps taking requests until it holds two, and then in_ready drops.
// Reset clears all widths, the frame timer and the pin levels, and loads
// frame_ticks with 5000, tick_shift with 2. Configuration writes take effect
// at once; the user makes them only while the block is idle (not enforced).

module multi_channel_servo_pulse_generator_core
  import mcspg_pkg::*;
#(
  parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FRAME_W-1:0]   cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 req_type,
  input  wire logic [SIDX_W-1:0]    servo_index,
  input  wire logic [WIDTH_W-1:0]   pulse_width,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PORT_B_W-1:0]       port_b_level,
  output logic [PORT_C_W-1:0]       port_c_level,
  output logic [PORT_D_W-1:0]       port_d_level,
  output logic                      frame_start
);

  logic [FRAME_W-1:0] frame_ticks;
  logic [SHIFT_W-1:0] tick_shift;
  cmd_t               front_cmd;
  cmd_t               queue_cmd;
  logic               queue_valid;
  logic               queue_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ticks <= FRAME_TICKS_RST;
      tick_shift  <= TICK_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_TICKS: frame_ticks <= cfg_data;
        CFG_TICK_SHIFT:  tick_shift  <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // The decoder classifies each request before it is queued.
  mcspg_front #(
    .NUM_SERVOS (NUM_SERVOS)
  ) u_front (
    .req_type    (req_type),
    .servo_index (servo_index),
    .pulse_width (pulse_width),
    .cmd         (front_cmd)
  );

  mcspg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_cmd    (queue_cmd)
  );

  // The engine holds widths, the frame timer and the registered pin levels.
  mcspg_back #(
    .NUM_SERVOS (NUM_SERVOS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (queue_valid),
    .cmd_ready    (queue_ready),
    .cmd          (queue_cmd),
    .frame_ticks  (frame_ticks),
    .tick_shift   (tick_shift),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .port_b_level (port_b_level),
    .port_c_level (port_c_level),
    .port_d_level (port_d_level),
    .frame_start  (frame_start)
  );

endmodule

`default_nettype wire

@@ design/mcspg_front.sv @@
`default_nettype none

module mcspg_front
  import mcspg_pkg::*;
#(
  parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
  input  wire logic               req_type,
  input  wire logic [SIDX_W-1:0]  servo_index,
  input  wire logic [WIDTH_W-1:0] pulse_width,
  output cmd_t                    cmd
);

  // A set request for a channel the block does not have is dropped here.
  always_comb begin
    cmd.is_tick = (req_type == REQ_TICK);
    cmd.set_en  = (req_type == REQ_SET) && (servo_index < SIDX_W'(NUM_SERVOS));
    cmd.index   = servo_index[IDX_W-1:0];
    cmd.width   = pulse_width;
  end

endmodule

`default_nettype wire

@@ design/mcspg_queue.sv @@
`default_nettype none

module mcspg_queue
  import mcspg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ design/mcspg_back.sv @@
`default_nettype none

module mcspg_back
  import mcspg_pkg::*;
#(
  parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  cmd_t                     cmd,
  input  wire logic [FRAME_W-1:0]  frame_ticks,
  input  wire logic [SHIFT_W-1:0]  tick_shift,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [PORT_B_W-1:0]      port_b_level,
  output logic [PORT_C_W-1:0]      port_c_level,
  output logic [PORT_D_W-1:0]      port_d_level,
  output logic                     frame_start
);

  // Channels beyond the pin map can never be seen, so only pinned ones are kept.
  localparam int NUM_PINS = (NUM_SERVOS < PIN_COUNT) ? NUM_SERVOS : PIN_COUNT;

  logic [WIDTH_W-1:0]  width_store  [NUM_PINS];
  logic [WIDTH_W-1:0]  frame_widths [NUM_PINS];
  logic [FRAME_W-1:0]  tick;
  logic [NUM_PINS-1:0] pin_levels;

  logic                started;
  logic [NUM_PINS-1:0] pin_levels_next;
  logic [FRAME_W-1:0]  frame_len;
  logic [FRAME_W:0]    tick_inc;
  logic [FRAME_W-1:0]  tick_next;
  logic                pop;

  assign cmd_ready = !out_valid || out_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign started   = (tick == '0);

  // The first tick of a frame compares against the widths it latches.
  always_comb begin
    for (int i = 0; i < NUM_PINS; i++) begin
      pin_levels_next[i] = {1'b0, tick} <
        ({1'b0, (started ? width_store[i] : frame_widths[i])} >> tick_shift);
    end
  end

  always_comb begin
    frame_len = (frame_ticks == '0) ? FRAME_W'(1) : frame_ticks;
    tick_inc  = {1'b0, tick} + (FRAME_W + 1)'(1);
    tick_next = (tick_inc >= {1'b0, frame_len}) ? '0 : tick_inc[FRAME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      frame_start <= 1'b0;
      tick        <= '0;
      pin_levels  <= '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        width_store[i]  <= '0;
        frame_widths[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (cmd.is_tick) begin
          pin_levels  <= pin_levels_next;
          frame_start <= started;
          tick        <= tick_next;
          if (started) begin
            for (int i = 0; i < NUM_PINS; i++) begin
              frame_widths[i] <= width_store[i];
            end
          end
        end else begin
          frame_start <= 1'b0;
        end
        for (int i = 0; i < NUM_PINS; i++) begin
          if (cmd.set_en && (cmd.index == IDX_W'(i))) begin
            width_store[i] <= cmd.width;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Fixed wiring of channel levels onto the three port groups.
  always_comb begin
    port_b_level = '0;
    port_c_level = '0;
    port_d_level = '0;
    for (int i = 0; i < NUM_PINS; i++) begin
      case (PIN_GROUP[i])
        GRP_B:   port_b_level[PIN_BIT[i]]      = pin_levels[i];
        GRP_C:   port_c_level[PIN_BIT[i][1:0]] = pin_levels[i];
        GRP_D:   port_d_level[PIN_BIT[i]]      = pin_levels[i];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/mcspg_checker.sv @@
`default_nettype none

module mcspg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] port_b_level,
  input wire logic [3:0] port_c_level,
  input wire logic [7:0] port_d_level,
  input wire logic       frame_start
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(port_b_level) &&
      $stable(port_c_level) && $stable(port_d_level) && $stable(frame_start))
    else $error("result changed while stalled");

  // The queue can only fill up behind a result that is waiting.
  a_full_needs_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output is empty");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind multi_channel_servo_pulse_generator_core mcspg_checker u_checker (.*);

`default_nettype wire
